### hdl/box_blur_3x3_rgb_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 box blur
// Implication checks on the rising clock edge, held off while in reset.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_RGB_TOP_ASSERT_SVH
`define BOX_BLUR_3X3_RGB_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define BB3_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bb3 assertion failed");
// next-cycle implication
`define BB3_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bb3 assertion failed");
`else
`define BB3_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BB3_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hdl/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Types and constants shared by the 3x3 box blur modules.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int CFG_W      = 11;
    localparam int SUM_W      = 10;   // column sum of three bytes
    localparam int WIN_W      = 12;   // window sum of nine bytes
    localparam int NUM_W      = 13;   // scaled numerator
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        FUNC_PIXEL = 1'b0,
        FUNC_DRAIN = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        DIV_4 = 2'd0,
        DIV_6 = 2'd1,
        DIV_9 = 2'd2
    } t_div_mode;

    typedef struct packed {
        t_func       func;
        logic [7:0]  blue_in;
        logic [7:0]  green_in;
        logic [7:0]  red_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0]  blue_out;
        logic [7:0]  green_out;
        logic [7:0]  red_out;
        logic        frame_end;
        logic        run_last;
    } t_pix_out;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_rgb;

    // one column of the window, summed over its rows
    typedef struct packed {
        logic              ok;
        logic [1:0]        rows;
        logic [SUM_W-1:0]  red;
        logic [SUM_W-1:0]  green;
        logic [SUM_W-1:0]  blue;
    } t_col;

    // window numerators handed to the scaling stage
    typedef struct packed {
        logic              valid;
        t_div_mode         mode;
        logic [NUM_W-1:0]  x_red;
        logic [NUM_W-1:0]  x_green;
        logic [NUM_W-1:0]  x_blue;
        logic              frame_end;
        logic              run_last;
    } t_scale_in;

    function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int hi);
        int t;
        t = int'(v);
        if (t < 2) t = 2;
        if (t > hi) t = hi;
        return t;
    endfunction

endpackage

### hdl/bb3_ram.sv
// ----------------------------------------------------------------------------
// bb3_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bb3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]          i_wdata,
    input  logic [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/bb3_cell.sv
// ----------------------------------------------------------------------------
// bb3_cell
// One column cell of the window chain; takes its neighbour's column on shift.
// ----------------------------------------------------------------------------
module bb3_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  logic          i_kill,
    input  bb3_pkg::t_col i_col,
    output bb3_pkg::t_col o_col
);

    bb3_pkg::t_col r_col;
    bb3_pkg::t_col n_col;

    // a kill marks the column as outside the window (new row started)
    always_comb begin
        n_col = i_col;
        if (i_kill) begin
            n_col.ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= n_col;
        end
    end

    assign o_col = r_col;

endmodule

### hdl/bb3_scale.sv
// ----------------------------------------------------------------------------
// bb3_scale
// Registered numerators times a reciprocal, giving the rounded window means.
// ----------------------------------------------------------------------------
module bb3_scale (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bb3_pkg::t_scale_in i_win,
    output logic               o_busy,
    output logic               o_push,
    output bb3_pkg::t_pix_out  o_item
);

    localparam int XW = bb3_pkg::NUM_W;
    localparam int KW = 18;
    localparam int PW = XW + KW;
    // floor(x/4), floor(x/6), floor(x/18) by multiply and shift
    localparam logic [KW-1:0] K_4 = 18'd65536;
    localparam logic [KW-1:0] K_6 = 18'd43691;
    localparam logic [KW-1:0] K_9 = 18'd233017;
    localparam int SH_4 = 18;
    localparam int SH_6 = 18;
    localparam int SH_9 = 22;

    bb3_pkg::t_scale_in r_win;

    function automatic logic [7:0] scale_chan(input logic [XW-1:0] x,
                                              input bb3_pkg::t_div_mode m);
        logic [PW-1:0] p;
        logic [7:0]    q;
        q = '0;
        case (m)
            bb3_pkg::DIV_4: begin
                p = PW'(x) * PW'(K_4);
                q = p[SH_4+7:SH_4];
            end
            bb3_pkg::DIV_6: begin
                p = PW'(x) * PW'(K_6);
                q = p[SH_6+7:SH_6];
            end
            bb3_pkg::DIV_9: begin
                p = PW'(x) * PW'(K_9);
                q = p[SH_9+7:SH_9];
            end
            default: q = '0;
        endcase
        return q;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.valid <= 1'b0;
        end else begin
            r_win.valid <= i_win.valid;
        end
        r_win.mode      <= i_win.mode;
        r_win.x_red     <= i_win.x_red;
        r_win.x_green   <= i_win.x_green;
        r_win.x_blue    <= i_win.x_blue;
        r_win.frame_end <= i_win.frame_end;
        r_win.run_last  <= i_win.run_last;
    end

    always_comb begin
        o_item.red_out   = scale_chan(r_win.x_red, r_win.mode);
        o_item.green_out = scale_chan(r_win.x_green, r_win.mode);
        o_item.blue_out  = scale_chan(r_win.x_blue, r_win.mode);
        o_item.frame_end = r_win.frame_end;
        o_item.run_last  = r_win.run_last;
    end

    assign o_push = r_win.valid;
    assign o_busy = r_win.valid;

endmodule

### hdl/bb3_fifo.sv
// ----------------------------------------------------------------------------
// bb3_fifo
// Small result queue between the blur pipeline and the output channel.
// ----------------------------------------------------------------------------
module bb3_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  bb3_pkg::t_pix_out             i_item,
    input  logic                          i_pop,
    output logic                          o_valid,
    output bb3_pkg::t_pix_out             o_item,
    output logic [bb3_pkg::FIFO_CW-1:0]   o_count
);

    localparam int AW = bb3_pkg::FIFO_AW;
    localparam int CW = bb3_pkg::FIFO_CW;

    bb3_pkg::t_pix_out r_mem [bb3_pkg::FIFO_DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_pop;

    assign do_pop = i_pop && (r_cnt != '0);

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + AW'(1);
            if (do_pop) r_rp <= r_rp + AW'(1);
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign o_count = r_cnt;

endmodule

### hdl/box_blur_3x3_rgb_top.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_top
// Streaming 3x3 box blur of an RGB frame, window clipped at the borders.
//
//  channel  dir  handshake                      payload
//  in       in   i_in_valid / o_in_ready        i_in_data  (t_pix_in)
//  out      out  o_out_valid / i_out_ready      o_out_data (t_pix_out)
//  cfg      in   i_cfg_we (no wait)             i_cfg_idx, i_cfg_data
//
// One item a cycle while the queue has room and no extra step is pending. A pixel
// closing a row of rows 1 and up, and the first drain item, each hold off input while the window chain steps once more.
// Results pass through stage 1, the window cells and the scaling register into an
// eight-entry queue; input stalls once queue plus pipeline hold eight results.
// Reset is synchronous; the line store is not cleared and needs no pass.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_rgb_top_assert.svh"

module box_blur_3x3_rgb_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  bb3_pkg::t_pix_in                i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output bb3_pkg::t_pix_out               o_out_data,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [bb3_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int CW = bb3_pkg::COL_W;
    localparam int RW = bb3_pkg::ROW_W;
    localparam int SW = bb3_pkg::SUM_W;
    localparam int WW = bb3_pkg::WIN_W;
    localparam int XW = bb3_pkg::NUM_W;
    localparam int QW = bb3_pkg::FIFO_CW;
    localparam logic [1:0] SLOT_ROW0 = 2'd0;
    localparam logic [1:0] SLOT_ROWM1 = 2'd2;
    localparam logic [1:0] SLOT_ROWM2 = 2'd1;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_TAIL  = 3'b010,
        PH_DRAIN = 3'b100
    } t_phase;

    // one step of the window chain
    typedef struct packed {
        logic          load;
        logic [1:0]    sel_a;
        logic          ok_a;
        logic [1:0]    sel_b;
        logic          ok_b;
        logic          ok_c;
        bb3_pkg::t_rgb px;
        logic          clear;
        logic          emit;
        logic          frame_end;
        logic          run_last;
    } t_op;

    // frame state
    logic [CW-1:0] r_w_m1, n_w_m1;
    logic [RW-1:0] r_h_m1, n_h_m1;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_drain_col, n_drain_col;
    logic          r_draining, n_draining;
    logic [1:0]    r_slot0, n_slot0;
    logic [1:0]    r_slot1, n_slot1;
    logic [1:0]    r_slot2, n_slot2;
    t_phase        r_phase, n_phase;

    // issue
    logic          credit_ok;
    logic          accept;
    logic          op_vld;
    t_op           op;
    logic [CW-1:0] op_addr;
    logic          op_we;
    logic          row_end;
    logic          last_row;
    logic          drain_last;
    logic [QW:0]   inflight;

    // pipeline
    logic          r_s1_vld;
    t_op           r_s1;
    bb3_pkg::t_rgb ram_q [3];
    bb3_pkg::t_col s1_col;
    bb3_pkg::t_col cell_in [3];
    bb3_pkg::t_col cell_q [3];
    logic          r_s2_emit;
    logic          r_s2_fe;
    logic          r_s2_rl;
    bb3_pkg::t_scale_in s2_win;

    // output
    logic               sc_busy;
    logic               sc_push;
    bb3_pkg::t_pix_out  sc_item;
    logic [QW-1:0]      q_count;

    // ---------------------------------------------------------------- credit
    assign inflight = (QW+1)'(q_count) + (QW+1)'(r_s1_vld && r_s1.emit)
                    + (QW+1)'(r_s2_emit) + (QW+1)'(sc_busy);
    assign credit_ok  = inflight < (QW+1)'(bb3_pkg::FIFO_DEPTH);
    assign o_in_ready = (r_phase == PH_IDLE) && credit_ok;
    assign accept     = i_in_valid && o_in_ready;

    assign row_end    = (r_col == r_w_m1);
    assign last_row   = (r_row == r_h_m1);
    assign drain_last = (r_drain_col == r_w_m1);

    // ----------------------------------------------------- sequencer / issue
    always_comb begin
        op          = '0;
        op_vld      = 1'b0;
        op_addr     = '0;
        op_we       = 1'b0;
        n_w_m1      = r_w_m1;
        n_h_m1      = r_h_m1;
        n_row       = r_row;
        n_col       = r_col;
        n_drain_col = r_drain_col;
        n_draining  = r_draining;
        n_slot0     = r_slot0;
        n_slot1     = r_slot1;
        n_slot2     = r_slot2;
        n_phase     = r_phase;

        unique case (r_phase)
            PH_IDLE: begin
                if (accept && (i_in_data.func == bb3_pkg::FUNC_DRAIN)) begin
                    if (r_draining) begin
                        op_vld   = 1'b1;
                        op.sel_a = r_slot1;
                        op.ok_a  = 1'b1;
                        op.sel_b = r_slot0;
                        op.ok_b  = 1'b1;
                        if (r_drain_col == '0) begin
                            // preload column 0, centre arrives next step
                            op.load     = 1'b1;
                            op.clear    = 1'b1;
                            n_drain_col = CW'(1);
                            n_phase     = PH_TAIL == PH_TAIL ? PH_DRAIN : PH_DRAIN;
                        end else if (drain_last) begin
                            op.emit      = 1'b1;
                            op.frame_end = 1'b1;
                            op.run_last  = 1'b1;
                            n_row        = '0;
                            n_col        = '0;
                            n_drain_col  = '0;
                            n_draining   = 1'b0;
                            n_slot0      = SLOT_ROW0;
                            n_slot1      = SLOT_ROWM1;
                            n_slot2      = SLOT_ROWM2;
                        end else begin
                            op.load     = 1'b1;
                            op.emit     = 1'b1;
                            op.run_last = 1'b1;
                            op_addr     = r_drain_col + CW'(1);
                            n_drain_col = r_drain_col + CW'(1);
                        end
                    end
                end else if (accept && !r_draining) begin
                    op_vld      = 1'b1;
                    op_we       = 1'b1;
                    op_addr     = r_col;
                    op.load     = 1'b1;
                    op.sel_a    = r_slot2;
                    op.ok_a     = (r_row > RW'(1));
                    op.sel_b    = r_slot1;
                    op.ok_b     = 1'b1;
                    op.ok_c     = 1'b1;
                    op.px.red   = i_in_data.red_in;
                    op.px.green = i_in_data.green_in;
                    op.px.blue  = i_in_data.blue_in;
                    op.clear    = (r_col == '0);
                    op.emit     = (r_row != '0) && (r_col != '0);
                    op.run_last = !row_end;
                    if (row_end) begin
                        n_col = '0;
                        if (r_row != '0) begin
                            n_phase = PH_TAIL;
                        end
                        if (last_row) begin
                            n_draining  = 1'b1;
                            n_drain_col = '0;
                        end else begin
                            n_row   = r_row + RW'(1);
                            n_slot0 = r_slot2;
                            n_slot1 = r_slot0;
                            n_slot2 = r_slot1;
                        end
                    end else begin
                        n_col = r_col + CW'(1);
                    end
                end
            end
            PH_TAIL: begin
                // empty column past the row end: right edge of the row above
                if (credit_ok) begin
                    op_vld      = 1'b1;
                    op.emit     = 1'b1;
                    op.run_last = 1'b1;
                    n_phase     = PH_IDLE;
                end
            end
            PH_DRAIN: begin
                // column 1 of the last rows, centre on column 0
                if (credit_ok) begin
                    op_vld      = 1'b1;
                    op.load     = 1'b1;
                    op.sel_a    = r_slot1;
                    op.ok_a     = 1'b1;
                    op.sel_b    = r_slot0;
                    op.ok_b     = 1'b1;
                    op.emit     = 1'b1;
                    op.run_last = 1'b1;
                    op_addr     = CW'(1);
                    n_phase     = PH_IDLE;
                end
            end
            default: n_phase = PH_IDLE;
        endcase

        // register write restarts the frame
        if (i_cfg_we) begin
            unique case (bb3_pkg::t_cfg_idx'(i_cfg_idx))
                bb3_pkg::CFG_WIDTH:
                    n_w_m1 = CW'(bb3_pkg::clamp_dim(i_cfg_data, bb3_pkg::MAX_WIDTH) - 1);
                bb3_pkg::CFG_HEIGHT:
                    n_h_m1 = RW'(bb3_pkg::clamp_dim(i_cfg_data, bb3_pkg::MAX_HEIGHT) - 1);
                default: n_w_m1 = r_w_m1;
            endcase
            n_row       = '0;
            n_col       = '0;
            n_drain_col = '0;
            n_draining  = 1'b0;
            n_slot0     = SLOT_ROW0;
            n_slot1     = SLOT_ROWM1;
            n_slot2     = SLOT_ROWM2;
            n_phase     = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_m1      <= CW'(640 - 1);
            r_h_m1      <= RW'(480 - 1);
            r_row       <= '0;
            r_col       <= '0;
            r_drain_col <= '0;
            r_draining  <= 1'b0;
            r_slot0     <= SLOT_ROW0;
            r_slot1     <= SLOT_ROWM1;
            r_slot2     <= SLOT_ROWM2;
            r_phase     <= PH_IDLE;
        end else begin
            r_w_m1      <= n_w_m1;
            r_h_m1      <= n_h_m1;
            r_row       <= n_row;
            r_col       <= n_col;
            r_drain_col <= n_drain_col;
            r_draining  <= n_draining;
            r_slot0     <= n_slot0;
            r_slot1     <= n_slot1;
            r_slot2     <= n_slot2;
            r_phase     <= n_phase;
        end
    end

    // ------------------------------------------- line store, one RAM per row
    for (genvar k = 0; k < 3; k++) begin : g_line
        bb3_ram #(
            .WIDTH ($bits(bb3_pkg::t_rgb)),
            .DEPTH (bb3_pkg::MAX_WIDTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (op_we && (r_slot0 == 2'(k))),
            .i_waddr (op_addr),
            .i_wdata (op.px),
            .i_raddr (op_addr),
            .o_rdata (ram_q[k])
        );
    end

    // stage 1 holds the step while the RAMs answer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= op_vld;
        end
        r_s1 <= op;
    end

    // column sum over the rows that lie inside the frame
    always_comb begin
        bb3_pkg::t_rgb a;
        bb3_pkg::t_rgb b;
        a = r_s1.ok_a ? ram_q[r_s1.sel_a] : '0;
        b = r_s1.ok_b ? ram_q[r_s1.sel_b] : '0;
        s1_col.ok    = r_s1.load;
        s1_col.rows  = 2'(r_s1.ok_a) + 2'(r_s1.ok_b) + 2'(r_s1.ok_c);
        s1_col.red   = SW'(a.red) + SW'(b.red)
                     + (r_s1.ok_c ? SW'(r_s1.px.red) : SW'(0));
        s1_col.green = SW'(a.green) + SW'(b.green)
                     + (r_s1.ok_c ? SW'(r_s1.px.green) : SW'(0));
        s1_col.blue  = SW'(a.blue) + SW'(b.blue)
                     + (r_s1.ok_c ? SW'(r_s1.px.blue) : SW'(0));
    end

    // ------------------------------- window chain: right, centre, left cells
    assign cell_in[0] = s1_col;
    assign cell_in[1] = cell_q[0];
    assign cell_in[2] = cell_q[1];

    for (genvar k = 0; k < 3; k++) begin : g_cell
        bb3_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (r_s1_vld),
            .i_kill  ((k != 0) && r_s1.clear),
            .i_col   (cell_in[k]),
            .o_col   (cell_q[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_emit <= 1'b0;
        end else begin
            r_s2_emit <= r_s1_vld && r_s1.emit;
        end
        r_s2_fe <= r_s1.frame_end;
        r_s2_rl <= r_s1.run_last;
    end

    function automatic logic [WW-1:0] add3(input logic [SW-1:0] a,
                                           input logic [SW-1:0] b,
                                           input logic [SW-1:0] c);
        return WW'(a) + WW'(b) + WW'(c);
    endfunction

    function automatic logic [XW-1:0] numer(input logic [WW-1:0] s,
                                            input bb3_pkg::t_div_mode m);
        logic [XW-1:0] x;
        case (m)
            bb3_pkg::DIV_4: x = XW'(s) + XW'(2);
            bb3_pkg::DIV_6: x = XW'(s) + XW'(3);
            bb3_pkg::DIV_9: x = {s, 1'b0} + XW'(9);
            default:        x = '0;
        endcase
        return x;
    endfunction

    // window sums and the divisor for the clipped window
    always_comb begin
        logic [SW-1:0] rr, rg, rb, lr, lg, lb;
        logic          cols3;
        logic          rows3;
        rr = cell_q[0].ok ? cell_q[0].red   : '0;
        rg = cell_q[0].ok ? cell_q[0].green : '0;
        rb = cell_q[0].ok ? cell_q[0].blue  : '0;
        lr = cell_q[2].ok ? cell_q[2].red   : '0;
        lg = cell_q[2].ok ? cell_q[2].green : '0;
        lb = cell_q[2].ok ? cell_q[2].blue  : '0;
        cols3 = cell_q[0].ok && cell_q[2].ok;
        rows3 = (cell_q[1].rows == 2'd3);
        if (rows3 && cols3) begin
            s2_win.mode = bb3_pkg::DIV_9;
        end else if (rows3 || cols3) begin
            s2_win.mode = bb3_pkg::DIV_6;
        end else begin
            s2_win.mode = bb3_pkg::DIV_4;
        end
        s2_win.valid     = r_s2_emit;
        s2_win.x_red     = numer(add3(rr, cell_q[1].red, lr), s2_win.mode);
        s2_win.x_green   = numer(add3(rg, cell_q[1].green, lg), s2_win.mode);
        s2_win.x_blue    = numer(add3(rb, cell_q[1].blue, lb), s2_win.mode);
        s2_win.frame_end = r_s2_fe;
        s2_win.run_last  = r_s2_rl;
    end

    // ------------------------------------------------------ scaling, queue
    bb3_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_win   (s2_win),
        .o_busy  (sc_busy),
        .o_push  (sc_push),
        .o_item  (sc_item)
    );

    bb3_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (sc_push),
        .i_item  (sc_item),
        .i_pop   (i_out_ready),
        .o_valid (o_out_valid),
        .o_item  (o_out_data),
        .o_count (q_count)
    );

    // ------------------------------------------------------------ checks
    `BB3_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, sc_push, q_count < QW'(bb3_pkg::FIFO_DEPTH))
    `BB3_ASSERT_IMP(a_tail_blocks, i_clk, i_rst_n, r_phase != PH_IDLE, !o_in_ready)
    `BB3_ASSERT_IMP(a_centre_ok, i_clk, i_rst_n, r_s2_emit, cell_q[1].ok)
    `BB3_ASSERT_IMP(a_drain_row, i_clk, i_rst_n, r_draining, r_row == r_h_m1)
    `BB3_ASSERT_NXT(a_drain_pre, i_clk, i_rst_n, op_vld && op.clear && !op_we, r_phase == PH_DRAIN)

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for box_blur_3x3_rgb_top
// Drives pixel and drain items through the valid/ready input channel and
// checks every result against an in-bench model of the clipped 3x3 blur.
// A short directed table comes first, then random frames of mostly small
// sizes and a few of the largest. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bb3_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             in_valid;
    logic             in_ready;
    t_pix_in          in_data;
    logic             out_valid;
    logic             out_ready;
    t_pix_out         out_data;
    logic             cfg_we;
    logic             cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    box_blur_3x3_rgb_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 16;

    // clock, 4 ns period
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- model
    logic [CFG_W-1:0] blur_width_reg;
    logic [CFG_W-1:0] blur_height_reg;
    int               row_pos;
    int               col_pos;
    int               drain_pos;
    bit               in_drain;
    t_rgb             row_store [3*MAX_WIDTH];
    t_pix_out         blur_q [$];

    int errors;
    int items_sent;
    int results_seen;
    int frames_done;

    function automatic int clip_size(logic [CFG_W-1:0] v, int hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    function automatic int slot(int r, int c);
        return (r % 3) * MAX_WIDTH + (c % MAX_WIDTH);
    endfunction

    function automatic t_pix_out blur_pixel(int r, int c, int h, int w, bit fe, bit rl);
        int r0, r1, c0, c1, n, sr, sg, sb;
        t_rgb px;
        t_pix_out res;
        r0 = (r > 0) ? r - 1 : 0;
        r1 = (r + 1 < h) ? r + 1 : h - 1;
        c0 = (c > 0) ? c - 1 : 0;
        c1 = (c + 1 < w) ? c + 1 : w - 1;
        n  = (r1 - r0 + 1) * (c1 - c0 + 1);
        sr = 0; sg = 0; sb = 0;
        for (int rr = r0; rr <= r1; rr++) begin
            for (int cc = c0; cc <= c1; cc++) begin
                px = row_store[slot(rr, cc)];
                sr += px.red; sg += px.green; sb += px.blue;
            end
        end
        // round half up
        res.red_out   = 8'((2 * sr + n) / (2 * n));
        res.green_out = 8'((2 * sg + n) / (2 * n));
        res.blue_out  = 8'((2 * sb + n) / (2 * n));
        res.frame_end = fe;
        res.run_last  = rl;
        return res;
    endfunction

    function automatic void restart_frame();
        row_pos = 0; col_pos = 0; drain_pos = 0; in_drain = 0;
    endfunction

    // push the results of one accepted item; returns 0 if the item is ignored
    // a known colour, where given, replaces the computed channels
    function automatic bit blur_predict(t_pix_in it, bit known, logic [7:0] kc);
        int w, h;
        bit row_end, emit_a, emit_b, last;
        t_pix_out res [2];
        int cnt;
        w = clip_size(blur_width_reg, MAX_WIDTH);
        h = clip_size(blur_height_reg, MAX_HEIGHT);
        cnt = 0;
        if (it.func == FUNC_DRAIN) begin
            if (!in_drain) return 0;
            last = (drain_pos + 1 >= w);
            res[0] = blur_pixel(h - 1, drain_pos, h, w, last, 1'b1);
            cnt = 1;
            if (last) begin
                restart_frame();
                frames_done++;
            end else begin
                drain_pos++;
            end
        end else begin
            if (in_drain) return 0;
            row_end = (col_pos + 1 >= w);
            emit_a  = (row_pos >= 1 && col_pos >= 1);
            emit_b  = (row_pos >= 1 && row_end);
            row_store[slot(row_pos, col_pos)] = '{red: it.red_in, green: it.green_in,
                                                  blue: it.blue_in};
            if (emit_a) res[cnt++] = blur_pixel(row_pos - 1, col_pos - 1, h, w, 0, !emit_b);
            if (emit_b) res[cnt++] = blur_pixel(row_pos - 1, w - 1, h, w, 0, 1'b1);
            if (row_end) begin
                col_pos = 0;
                if (row_pos + 1 >= h) begin
                    in_drain = 1; drain_pos = 0;
                end else begin
                    row_pos++;
                end
            end else begin
                col_pos++;
            end
        end
        for (int k = 0; k < cnt; k++) begin
            if (known) begin
                res[k].red_out = kc; res[k].green_out = kc; res[k].blue_out = kc;
            end
            blur_q.push_back(res[k]);
        end
        return 1;
    endfunction

    // ---------------------------------------------------------------- sender
    int burst_left;

    task automatic send_item(t_pix_in it, bit known, logic [7:0] kc);
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (!in_ready);
        if (blur_predict(it, known, kc)) items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // gap, then a new burst; now and then a long stretch with no gap
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(0, 25);
        end
    endtask

    // lower valid in this step and wait for every expected result
    task automatic drain_wait();
        in_valid <= 1'b0;
        while (blur_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [CFG_W-1:0] v);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        if (idx == CFG_WIDTH) blur_width_reg = v;
        else blur_height_reg = v;
        restart_frame();
    endtask

    task automatic set_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        drain_wait();
        cfg_write(CFG_WIDTH, w);
        cfg_write(CFG_HEIGHT, h);
    endtask

    function automatic t_pix_in rand_pixel();
        t_pix_in p;
        p.func = FUNC_PIXEL;
        case ($urandom_range(0, 9))
            0: {p.red_in, p.green_in, p.blue_in} = '1;
            1: {p.red_in, p.green_in, p.blue_in} = '0;
            default: {p.red_in, p.green_in, p.blue_in} = 24'($urandom);
        endcase
        return p;
    endfunction

    function automatic t_pix_in drain_item();
        t_pix_in p;
        p.func = FUNC_DRAIN;
        {p.red_in, p.green_in, p.blue_in} = 24'($urandom);
        return p;
    endfunction

    // one frame with random content and a little noise; a broken frame stops early
    task automatic run_frame(bit broken);
        int w, h, npix, ndrain;
        w = clip_size(blur_width_reg, MAX_WIDTH);
        h = clip_size(blur_height_reg, MAX_HEIGHT);
        npix   = broken ? $urandom_range(1, w * h) : w * h;
        ndrain = (npix == w * h) ? (broken ? $urandom_range(0, w - 1) : w) : 0;
        for (int k = 0; k < npix; k++) begin
            if ($urandom_range(0, 40) == 0) send_item(drain_item(), 0, 8'h00);
            send_item(rand_pixel(), 0, 8'h00);
        end
        for (int k = 0; k < ndrain; k++) begin
            if ($urandom_range(0, 20) == 0) send_item(rand_pixel(), 0, 8'h00);
            send_item(drain_item(), 0, 8'h00);
        end
    endtask

    // ---------------------------------------------------------------- receiver
    int hold_req;
    int hold_done;
    int hold_left;
    int stall_mode;
    int mode_left;

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (hold_req != hold_done) begin
            hold_done <= hold_req;
            hold_left <= 120;
            out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(20, 80);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= $urandom_range(0, 1);
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= (mode_left % 7 != 0);
            endcase
        end
    end

    // ---------------------------------------------------------------- checker
    always @(posedge i_clk) begin
        t_pix_out exp_res;
        if (i_rst_n && out_valid && out_ready) begin
            results_seen++;
            if (blur_q.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, actual %h", $realtime, out_data);
            end else begin
                exp_res = blur_q.pop_front();
                if (exp_res.red_out !== out_data.red_out) begin
                    errors++;
                    $display("%0t: red_out expected %h actual %h", $realtime,
                             exp_res.red_out, out_data.red_out);
                end
                if (exp_res.green_out !== out_data.green_out) begin
                    errors++;
                    $display("%0t: green_out expected %h actual %h", $realtime,
                             exp_res.green_out, out_data.green_out);
                end
                if (exp_res.blue_out !== out_data.blue_out) begin
                    errors++;
                    $display("%0t: blue_out expected %h actual %h", $realtime,
                             exp_res.blue_out, out_data.blue_out);
                end
                if (exp_res.frame_end !== out_data.frame_end) begin
                    errors++;
                    $display("%0t: frame_end expected %b actual %b", $realtime,
                             exp_res.frame_end, out_data.frame_end);
                end
                if (exp_res.run_last !== out_data.run_last) begin
                    errors++;
                    $display("%0t: run_last expected %b actual %b", $realtime,
                             exp_res.run_last, out_data.run_last);
                end
            end
        end
    end

    // watchdog: cycles with no item moving on either channel
    int quiet_cycles;
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $realtime,
                     blur_q.size());
            $display("tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- stimulus
    typedef struct {
        t_pix_in    item;
        bit         known;
        logic [7:0] colour;
    } stim_row_t;

    stim_row_t directed [$];

    function automatic void add_row(t_func f, logic [7:0] r, logic [7:0] g,
                                    logic [7:0] b, bit known, logic [7:0] kc);
        stim_row_t s;
        s.item   = '{func: f, blue_in: b, green_in: g, red_in: r};
        s.known  = known;
        s.colour = kc;
        directed.push_back(s);
    endfunction

    initial begin
        in_valid   = 1'b0;
        in_data    = '0;
        out_ready  = 1'b0;
        cfg_we     = 1'b0;
        cfg_idx    = CFG_WIDTH;
        cfg_data   = '0;
        hold_req   = 0;
        hold_done  = 0;
        hold_left  = 0;
        stall_mode = 0;
        mode_left  = 0;
        quiet_cycles = 0;
        errors = 0; items_sent = 0; results_seen = 0; frames_done = 0;
        burst_left = 0;
        blur_width_reg  = 11'd640;
        blur_height_reg = 11'd480;
        restart_frame();
        for (int k = 0; k < 3 * MAX_WIDTH; k++) row_store[k] = '0;

        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // 2x2 frames: flat white, flat black with noise, then primaries
        add_row(FUNC_DRAIN, 8'hff, 8'hff, 8'hff, 0, 8'h00); // drain while idle
        repeat (4) add_row(FUNC_PIXEL, 8'hff, 8'hff, 8'hff, 1, 8'hff);
        add_row(FUNC_DRAIN, 8'ha5, 8'h5a, 8'h3c, 1, 8'hff);
        add_row(FUNC_DRAIN, 8'h00, 8'h00, 8'h00, 1, 8'hff);
        repeat (4) add_row(FUNC_PIXEL, 8'h00, 8'h00, 8'h00, 1, 8'h00);
        add_row(FUNC_DRAIN, 8'hff, 8'hff, 8'hff, 1, 8'h00);
        add_row(FUNC_PIXEL, 8'hff, 8'hff, 8'hff, 0, 8'h00); // pixel while draining
        add_row(FUNC_DRAIN, 8'hff, 8'hff, 8'hff, 1, 8'h00);
        add_row(FUNC_PIXEL, 8'hff, 8'h00, 8'h00, 0, 8'h00);
        add_row(FUNC_PIXEL, 8'h00, 8'hff, 8'h00, 0, 8'h00);
        add_row(FUNC_PIXEL, 8'h00, 8'h00, 8'hff, 0, 8'h00);
        add_row(FUNC_PIXEL, 8'h01, 8'h02, 8'h03, 0, 8'h00);
        add_row(FUNC_DRAIN, 8'h00, 8'h00, 8'h00, 0, 8'h00);
        add_row(FUNC_DRAIN, 8'h00, 8'h00, 8'h00, 0, 8'h00);

        set_size(11'd2, 11'd2);
        foreach (directed[k]) send_item(directed[k].item, directed[k].known,
                                        directed[k].colour);

        // random frames; the first few hit the size extremes and clamping
        for (int phase = 0; items_sent < 1400 + 4 * MAX_WIDTH; phase++) begin
            case (phase)
                0: set_size(11'd2047, 11'd2);   // width clamps to the maximum
                1: set_size(11'd2, 11'd2047);   // height clamps to the maximum
                2: set_size(11'd0, 11'd1);      // both clamp up to two
                3: set_size(11'd1024, 11'd3);
                default: begin
                    if ($urandom_range(0, 9) == 0)
                        set_size(11'($urandom_range(0, 1)), 11'($urandom_range(2, 5)));
                    else
                        set_size(11'($urandom_range(2, 9)), 11'($urandom_range(2, 6)));
                end
            endcase
            if (phase == 5) hold_req++;          // long receiver hold-off
            if (phase == 7) drain_wait();        // sender waits for every result
            run_frame(phase > 4 && $urandom_range(0, 5) == 0);
            if ($urandom_range(0, 3) == 0) run_frame(0); // back-to-back frame
        end

        drain_wait();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("run covered %0d accepted items, %0d results and %0d whole frames,",
                 items_sent, results_seen, frames_done);
        $display("sizes from clamped two up to the largest, with noise and broken frames");
        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("tb failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/bb3_pkg.sv
hdl/bb3_ram.sv
hdl/bb3_cell.sv
hdl/bb3_scale.sv
hdl/bb3_fifo.sv
hdl/box_blur_3x3_rgb_top.sv
test/tb.sv
